FILE: design/gcfc_pkg.sv
// ----------------------------------------------------------------------------
// gcfc_pkg
// Shared types and constants of the gimbal command frame controller.
// ----------------------------------------------------------------------------
package gcfc_pkg;

    // Frame bytes.
    localparam logic [7:0] BYTE_HEADER   = 8'hAA;
    localparam logic [7:0] BYTE_SPEED    = 8'hBB;
    localparam logic [7:0] BYTE_POSITION = 8'hDD;
    localparam logic [7:0] BYTE_TRAILER  = 8'hCC;

    // Item kinds.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // Command kinds and axes.
    localparam logic CMD_SPEED    = 1'b0;
    localparam logic CMD_POSITION = 1'b1;
    localparam logic AXIS_H       = 1'b0;
    localparam logic AXIS_V       = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_IDX_W          = 3;
    localparam logic [2:0]  CFG_RX_TIMEOUT     = 3'd0;
    localparam logic [2:0]  CFG_SEND_INTERVAL  = 3'd1;
    localparam logic [2:0]  CFG_SPEED_DEADBAND = 3'd2;
    localparam logic [2:0]  CFG_SPEED_ACCEL    = 3'd3;
    localparam logic [2:0]  CFG_POSITION_ACCEL = 3'd4;
    localparam logic [2:0]  CFG_POSITION_RPM   = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_RX_TIMEOUT     = 16'd200;
    localparam logic [15:0] RST_SEND_INTERVAL  = 16'd20;
    localparam logic [15:0] RST_SPEED_DEADBAND = 16'd2;
    localparam logic [7:0]  RST_SPEED_ACCEL    = 8'd20;
    localparam logic [7:0]  RST_POSITION_ACCEL = 8'd5;
    localparam logic [15:0] RST_POSITION_RPM   = 16'd200;

    // Last commanded position after reset (-999999).
    localparam logic [31:0] POS_SENTINEL = 32'hFFF0BDC1;

    typedef struct packed {
        logic [15:0] rx_timeout_ms;
        logic [15:0] update_gap_ms;
        logic [15:0] speed_threshold;
        logic [7:0]  speed_accel;
        logic [7:0]  position_accel;
        logic [15:0] position_rpm;
    } cfg_t;

    // Frame event from the parser for the item in hand.
    typedef struct packed {
        logic        commit;
        logic        is_position;
        logic [63:0] payload;
    } frame_t;

    // One motor command.
    typedef struct packed {
        logic        axis;
        logic        cmd_kind;
        logic        direction;
        logic [7:0]  accel;
        logic [15:0] speed_rpm;
        logic [31:0] pulse_count;
        logic        last;
    } res_t;

endpackage

FILE: design/gcfc_parser.sv
// ----------------------------------------------------------------------------
// gcfc_parser
// Byte framer: finds header, type, payload and trailer, holds the payload.
// ----------------------------------------------------------------------------
module gcfc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output gcfc_pkg::frame_t     frame
);
    import gcfc_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_TYPE    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic       is_pos_reg, is_pos_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] payload_reg [8];
    logic [3:0] count_inc;

    assign count_inc = count_reg + 4'd1;

    always_comb begin
        phase_next  = phase_reg;
        is_pos_next = is_pos_reg;
        count_next  = count_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == BYTE_HEADER) phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                if (rx_byte == BYTE_SPEED || rx_byte == BYTE_POSITION) begin
                    is_pos_next = (rx_byte == BYTE_POSITION);
                    count_next  = 4'd0;
                    phase_next  = PH_PAYLOAD;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                count_next = count_inc;
                if (count_inc >= (is_pos_reg ? 4'd8 : 4'd4)) phase_next = PH_TRAILER;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            is_pos_reg <= 1'b0;
            count_reg  <= 4'd0;
        end else if (byte_en) begin
            phase_reg  <= phase_next;
            is_pos_reg <= is_pos_next;
            count_reg  <= count_next;
        end
    end

    // Payload store has no reset: a frame only commits once it is full.
    always_ff @(posedge aclk) begin
        if (byte_en && phase_reg == PH_PAYLOAD) begin
            payload_reg[count_reg[2:0]] <= rx_byte;
        end
    end

    assign frame.commit      = (phase_reg == PH_TRAILER) && (rx_byte == BYTE_TRAILER);
    assign frame.is_position = is_pos_reg;
    assign frame.payload     = {payload_reg[7], payload_reg[6], payload_reg[5], payload_reg[4],
                                payload_reg[3], payload_reg[2], payload_reg[1], payload_reg[0]};

endmodule

FILE: design/gcfc_cmd.sv
// ----------------------------------------------------------------------------
// gcfc_cmd
// Motor command decisions: speed mode, link watchdog, deadband and position.
// ----------------------------------------------------------------------------
module gcfc_cmd (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 req_type,
    input  logic [31:0]          now_ms,
    input  gcfc_pkg::frame_t     frame,
    input  gcfc_pkg::cfg_t       cfg,
    output logic [1:0]           res_count,
    output gcfc_pkg::res_t       res0,
    output gcfc_pkg::res_t       res1
);
    import gcfc_pkg::*;

    logic        mode_reg, mode_next;
    logic [15:0] tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [15:0] sent_x_reg, sent_x_next, sent_y_reg, sent_y_next;
    logic [31:0] rx_time_reg, rx_time_next, send_time_reg, send_time_next;
    logic [31:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;

    logic [31:0] rx_age, send_age, px, py;
    logic        stale, interval_ok, x_chg, y_chg, big_change;
    logic [16:0] dx, dy, adx, ady;
    res_t        cmd_px, cmd_py, cmd_sx, cmd_sy, cmd_stop_x, cmd_stop_y;

    assign rx_age      = now_ms - rx_time_reg;
    assign send_age    = now_ms - send_time_reg;
    assign stale       = rx_age > {16'd0, cfg.rx_timeout_ms};
    assign interval_ok = send_age >= {16'd0, cfg.update_gap_ms};

    assign dx  = {tgt_x_reg[15], tgt_x_reg} - {sent_x_reg[15], sent_x_reg};
    assign dy  = {tgt_y_reg[15], tgt_y_reg} - {sent_y_reg[15], sent_y_reg};
    assign adx = dx[16] ? (17'd0 - dx) : dx;
    assign ady = dy[16] ? (17'd0 - dy) : dy;
    assign big_change = !((adx < {1'b0, cfg.speed_threshold}) &&
                          (ady < {1'b0, cfg.speed_threshold}));

    assign px    = frame.payload[31:0];
    assign py    = frame.payload[63:32];
    assign x_chg = px != prev_x_reg;
    assign y_chg = py != prev_y_reg;

    function automatic res_t pos_cmd(input logic ax, input logic [31:0] p,
                                     input logic [7:0] acc, input logic [15:0] rpm);
        res_t r;
        r.axis        = ax;
        r.cmd_kind    = CMD_POSITION;
        r.direction   = p[31];
        r.accel       = acc;
        r.speed_rpm   = rpm;
        r.pulse_count = p[31] ? (32'd0 - p) : p;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic res_t spd_cmd(input logic ax, input logic [15:0] s,
                                     input logic [7:0] acc);
        res_t r;
        r.axis        = ax;
        r.cmd_kind    = CMD_SPEED;
        r.direction   = s[15];
        r.accel       = acc;
        r.speed_rpm   = s[15] ? (16'd0 - s) : s;
        r.pulse_count = 32'd0;
        r.last        = 1'b0;
        return r;
    endfunction

    assign cmd_px     = pos_cmd(AXIS_H, px, cfg.position_accel, cfg.position_rpm);
    assign cmd_py     = pos_cmd(AXIS_V, py, cfg.position_accel, cfg.position_rpm);
    assign cmd_sx     = spd_cmd(AXIS_H, tgt_x_reg, cfg.speed_accel);
    assign cmd_sy     = spd_cmd(AXIS_V, tgt_y_reg, cfg.speed_accel);
    assign cmd_stop_x = spd_cmd(AXIS_H, 16'd0, 8'd0);
    assign cmd_stop_y = spd_cmd(AXIS_V, 16'd0, 8'd0);

    always_comb begin
        mode_next      = mode_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        sent_x_next    = sent_x_reg;
        sent_y_next    = sent_y_reg;
        rx_time_next   = rx_time_reg;
        send_time_next = send_time_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        res_count      = 2'd0;
        res0           = cmd_stop_x;
        res1           = cmd_stop_y;
        if (req_type == REQ_POLL) begin
            if (stale) begin
                if (mode_reg) begin
                    mode_next   = 1'b0;
                    sent_x_next = 16'd0;
                    sent_y_next = 16'd0;
                    res_count   = 2'd2;
                end
            end else if (mode_reg && interval_ok) begin
                send_time_next = now_ms;
                if (big_change) begin
                    sent_x_next = tgt_x_reg;
                    sent_y_next = tgt_y_reg;
                    res0        = cmd_sx;
                    res1        = cmd_sy;
                    res_count   = 2'd2;
                end
            end
        end else if (frame.commit) begin
            rx_time_next = now_ms;
            if (!frame.is_position) begin
                mode_next  = 1'b1;
                tgt_x_next = frame.payload[15:0];
                tgt_y_next = frame.payload[31:16];
            end else begin
                mode_next = 1'b0;
                if (x_chg) prev_x_next = px;
                if (y_chg) prev_y_next = py;
                res0      = x_chg ? cmd_px : cmd_py;
                res1      = cmd_py;
                res_count = {1'b0, x_chg} + {1'b0, y_chg};
            end
        end
        // The final command of the item carries the last flag.
        res0.last = (res_count == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            tgt_x_reg     <= 16'd0;
            tgt_y_reg     <= 16'd0;
            sent_x_reg    <= 16'd0;
            sent_y_reg    <= 16'd0;
            rx_time_reg   <= 32'd0;
            send_time_reg <= 32'd0;
            prev_x_reg    <= POS_SENTINEL;
            prev_y_reg    <= POS_SENTINEL;
        end else if (en) begin
            mode_reg      <= mode_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            sent_x_reg    <= sent_x_next;
            sent_y_reg    <= sent_y_next;
            rx_time_reg   <= rx_time_next;
            send_time_reg <= send_time_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
        end
    end

endmodule

FILE: design/gcfc_outq.sv
// ----------------------------------------------------------------------------
// gcfc_outq
// Four-entry result queue taking up to two commands per cycle.
// ----------------------------------------------------------------------------
module gcfc_outq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_count,
    input  gcfc_pkg::res_t       push0,
    input  gcfc_pkg::res_t       push1,
    output logic                 room2,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gcfc_pkg::res_t       out_data
);
    import gcfc_pkg::*;

    res_t       mem_reg [4];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] count_reg;
    logic       pop;

    assign out_valid = count_reg != 3'd0;
    assign room2     = count_reg <= 3'd2;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[head_reg];

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) mem_reg[tail_reg] <= push0;
        if (push_count == 2'd2) mem_reg[tail_reg + 2'd1] <= push1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            head_reg  <= head_reg + {1'b0, pop};
            tail_reg  <= tail_reg + push_count;
            count_reg <= count_reg + {1'b0, push_count} - {2'd0, pop};
        end
    end

endmodule

FILE: design/gimbal_command_frame_controller_unit.sv
// ----------------------------------------------------------------------------
// gimbal_command_frame_controller_unit
// Turns received serial bytes and control polls into gimbal motor commands.
// ----------------------------------------------------------------------------
// Each input word is either a received byte or a control poll, tagged with the
// millisecond time. Words are taken into an input register and handled there,
// and the commands they cause (none, one or two) go into a four-entry output
// queue that presents one command word per cycle while the receiver takes
// them. A word is handled as soon as the queue has room for two commands, so
// the block takes one word per cycle while the output side keeps up; words that
// cause two commands are limited by the single queue read port in the long run.
// The first command of a word passes through the input register and then the
// output queue before it is presented.
// Configuration writes take effect on the next clock edge and are meant to be
// made while no word is in flight.
// ----------------------------------------------------------------------------
module gimbal_command_frame_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [gcfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata,
    // Input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [7:0]                     s_rx_byte,
    input  logic [31:0]                    s_now_ms,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_axis,
    output logic                           m_cmd_kind,
    output logic                           m_direction,
    output logic [7:0]                     m_accel,
    output logic [15:0]                    m_speed_rpm,
    output logic [31:0]                    m_pulse_count,
    output logic                           m_last
);
    import gcfc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_req_type_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_now_reg;
    logic        room2, proc, s_accept;
    frame_t      frame;
    logic [1:0]  res_count;
    res_t        res0, res1, out_word;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rx_timeout_ms   <= RST_RX_TIMEOUT;
            cfg_reg.update_gap_ms   <= RST_SEND_INTERVAL;
            cfg_reg.speed_threshold <= RST_SPEED_DEADBAND;
            cfg_reg.speed_accel     <= RST_SPEED_ACCEL;
            cfg_reg.position_accel  <= RST_POSITION_ACCEL;
            cfg_reg.position_rpm    <= RST_POSITION_RPM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RX_TIMEOUT:     cfg_reg.rx_timeout_ms   <= cfg_wdata;
                CFG_SEND_INTERVAL:  cfg_reg.update_gap_ms   <= cfg_wdata;
                CFG_SPEED_DEADBAND: cfg_reg.speed_threshold <= cfg_wdata;
                CFG_SPEED_ACCEL:    cfg_reg.speed_accel     <= cfg_wdata[7:0];
                CFG_POSITION_ACCEL: cfg_reg.position_accel  <= cfg_wdata[7:0];
                CFG_POSITION_RPM:   cfg_reg.position_rpm    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The held word is handled when the queue can take both of its possible
    // commands; the register then frees up for the next word in the same cycle.
    assign proc     = in_valid_reg && room2;
    assign s_ready  = !in_valid_reg || proc;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_type_reg <= s_req_type;
            in_byte_reg     <= s_rx_byte;
            in_now_reg      <= s_now_ms;
        end
    end

    gcfc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (proc && in_req_type_reg == REQ_BYTE),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    gcfc_cmd u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (proc),
        .req_type  (in_req_type_reg),
        .now_ms    (in_now_reg),
        .frame     (frame),
        .cfg       (cfg_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    // Nothing is pushed unless the word is actually being handled.
    gcfc_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (proc ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_word)
    );

    assign m_axis        = out_word.axis;
    assign m_cmd_kind    = out_word.cmd_kind;
    assign m_direction   = out_word.direction;
    assign m_accel       = out_word.accel;
    assign m_speed_rpm   = out_word.speed_rpm;
    assign m_pulse_count = out_word.pulse_count;
    assign m_last        = out_word.last;

endmodule

FILE: design/gcfc_checker.sv
// ----------------------------------------------------------------------------
// gcfc_checker
// Port-level checks on the command stream of the frame controller.
// ----------------------------------------------------------------------------
module gcfc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_axis,
    input  logic        m_cmd_kind,
    input  logic [31:0] m_pulse_count,
    input  logic        m_last
);
    import gcfc_pkg::*;

    // A stalled command word stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("command word withdrawn while stalled");

    // Speed commands carry no pulse count.
    a_speed_pulses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cmd_kind == CMD_SPEED |-> m_pulse_count == 32'd0)
        else $error("speed command with non-zero pulse count");

    // Speed commands come in pairs: the horizontal one is never the last.
    a_speed_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cmd_kind == CMD_SPEED && m_axis == AXIS_H |-> !m_last)
        else $error("horizontal speed command flagged last");

    // A vertical command always ends its word.
    a_vertical_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_axis == AXIS_V |-> m_last)
        else $error("vertical command not flagged last");

endmodule

bind gimbal_command_frame_controller_unit gcfc_checker u_gcfc_checker (.*);

FILE: tb/gimbal_command_frame_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// gimbal_command_frame_controller_unit_tb
// Self-checking testbench of the gimbal command frame controller.
// ----------------------------------------------------------------------------
// A short table of directed words is sent first: stale polls, a wrong type
// byte, a speed frame and a position frame carrying the most negative and most
// positive values, a stale link stopping the motors and a bad trailer. Random
// phases follow, each under its own register setting, mixing well-formed
// frames with polls, noise and broken frames. Every accepted word is run
// through a predictor of the block; its commands, or those typed in for it,
// are compared field by field with what the block presents on its result port.
// ----------------------------------------------------------------------------
module gimbal_command_frame_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gcfc_pkg::*;

    // Cycles with no word moving on either port, while work is pending, before giving up.
    localparam int STALL_LIMIT   = 2000;
    // Cycles left after the last command so that silent words can finish.
    localparam int SETTLE_CYCLES = 8;
    // Marks a stimulus row whose commands come from the predictor.
    localparam int PREDICT       = -1;
    // Long hold-off of the receiver and the spacing between such holds.
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_SPACING  = 2500;
    // Words generated in each random phase, and the number of those phases.
    localparam int PHASE_WORDS   = 380;
    localparam int RANDOM_PHASES = 5;

    typedef enum logic [1:0] {PH_HUNT, PH_TYPE, PH_PAYLOAD, PH_TRAILER} parse_ph_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_PERIODIC} rdy_mode_t;

    // One input word, with the commands typed in where they are obvious.
    typedef struct {
        logic        req_type;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
        int          n_fixed;
        res_t        fix0;
        res_t        fix1;
    } word_t;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [15:0]          cfg_wdata  = '0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = 1'b0;
    logic [7:0]           s_rx_byte  = '0;
    logic [31:0]          s_now_ms   = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic                 m_axis;
    logic                 m_cmd_kind;
    logic                 m_direction;
    logic [7:0]           m_accel;
    logic [15:0]          m_speed_rpm;
    logic [31:0]          m_pulse_count;
    logic                 m_last;

    gimbal_command_frame_controller_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_axis        (m_axis),
        .m_cmd_kind    (m_cmd_kind),
        .m_direction   (m_direction),
        .m_accel       (m_accel),
        .m_speed_rpm   (m_speed_rpm),
        .m_pulse_count (m_pulse_count),
        .m_last        (m_last)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state: the registers as last written and the block's own state.
    // ------------------------------------------------------------------------
    cfg_t        cfg;
    parse_ph_t   parse_ph;
    logic        frame_pos;
    logic [7:0]  payload [8];
    logic [3:0]  pay_cnt;
    logic        spd_mode;
    logic [15:0] tgt_x, tgt_y, sent_x, sent_y;
    logic [31:0] last_rx_ms, last_send_ms, cmd_pos_x, cmd_pos_y;

    // Commands caused by the word in hand, then the ones still to arrive.
    res_t        new_cmds [2];
    int          new_count;
    res_t        motor_cmd_q [$];

    // Words waiting to be sent, the directed table and the word on offer.
    word_t       tx_words [$];
    word_t       dir_tab [$];
    word_t       cur_word;
    word_t       nxt_word;

    int          errors = 0;

    // Random generator state: time and the values last put into frames.
    logic [31:0] gen_now = 32'd500;
    int          gen_count;
    logic [15:0] gen_sx = '0, gen_sy = '0;
    logic [31:0] gen_px = '0, gen_py = '0;

    task automatic reset_predictor();
        cfg = '{RST_RX_TIMEOUT, RST_SEND_INTERVAL, RST_SPEED_DEADBAND,
                RST_SPEED_ACCEL, RST_POSITION_ACCEL, RST_POSITION_RPM};
        parse_ph     = PH_HUNT;
        frame_pos    = 1'b0;
        foreach (payload[i]) payload[i] = '0;
        pay_cnt      = '0;
        spd_mode     = 1'b0;
        tgt_x        = '0;
        tgt_y        = '0;
        sent_x       = '0;
        sent_y       = '0;
        last_rx_ms   = '0;
        last_send_ms = '0;
        cmd_pos_x    = POS_SENTINEL;
        cmd_pos_y    = POS_SENTINEL;
    endtask

    task automatic add_cmd(logic ax, logic kind, logic dir, logic [7:0] acc,
                           logic [15:0] rpm, logic [31:0] pulses);
        new_cmds[new_count] = res_t'{ax, kind, dir, acc, rpm, pulses, 1'b0};
        new_count++;
    endtask

    // Works out the motor commands of one word and moves the state on.
    task automatic predict_motor_cmds(input word_t w);
        logic [31:0] px, py;
        int          dx, dy;
        new_count = 0;
        if (w.req_type == REQ_POLL) begin
            if (w.now_ms - last_rx_ms > {16'd0, cfg.rx_timeout_ms}) begin
                // The link has gone quiet: stop both motors, but only once.
                if (spd_mode) begin
                    spd_mode = 1'b0;
                    add_cmd(AXIS_H, CMD_SPEED, 1'b0, 8'd0, 16'd0, 32'd0);
                    add_cmd(AXIS_V, CMD_SPEED, 1'b0, 8'd0, 16'd0, 32'd0);
                    sent_x = '0;
                    sent_y = '0;
                end
            end else if (spd_mode &&
                         w.now_ms - last_send_ms >= {16'd0, cfg.update_gap_ms}) begin
                // The send time moves on even when no axis changed enough.
                last_send_ms = w.now_ms;
                dx = int'($signed(tgt_x)) - int'($signed(sent_x));
                dy = int'($signed(tgt_y)) - int'($signed(sent_y));
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx >= int'(cfg.speed_threshold) || dy >= int'(cfg.speed_threshold)) begin
                    sent_x = tgt_x;
                    sent_y = tgt_y;
                    add_cmd(AXIS_H, CMD_SPEED, tgt_x[15], cfg.speed_accel,
                            tgt_x[15] ? 16'd0 - tgt_x : tgt_x, 32'd0);
                    add_cmd(AXIS_V, CMD_SPEED, tgt_y[15], cfg.speed_accel,
                            tgt_y[15] ? 16'd0 - tgt_y : tgt_y, 32'd0);
                end
            end
        end else begin
            case (parse_ph)
                PH_HUNT: begin
                    if (w.rx_byte == BYTE_HEADER) parse_ph = PH_TYPE;
                end
                PH_TYPE: begin
                    // A wrong type byte is dropped, even when it is a header.
                    if (w.rx_byte == BYTE_SPEED || w.rx_byte == BYTE_POSITION) begin
                        frame_pos = (w.rx_byte == BYTE_POSITION);
                        pay_cnt   = '0;
                        parse_ph  = PH_PAYLOAD;
                    end else begin
                        parse_ph = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    payload[pay_cnt[2:0]] = w.rx_byte;
                    pay_cnt = pay_cnt + 4'd1;
                    if (pay_cnt >= (frame_pos ? 4'd8 : 4'd4)) parse_ph = PH_TRAILER;
                end
                default: begin
                    if (w.rx_byte == BYTE_TRAILER) begin
                        last_rx_ms = w.now_ms;
                        if (!frame_pos) begin
                            spd_mode = 1'b1;
                            tgt_x    = {payload[1], payload[0]};
                            tgt_y    = {payload[3], payload[2]};
                        end else begin
                            px = {payload[3], payload[2], payload[1], payload[0]};
                            py = {payload[7], payload[6], payload[5], payload[4]};
                            spd_mode = 1'b0;
                            if (px != cmd_pos_x) begin
                                add_cmd(AXIS_H, CMD_POSITION, px[31], cfg.position_accel,
                                        cfg.position_rpm, px[31] ? 32'd0 - px : px);
                                cmd_pos_x = px;
                            end
                            if (py != cmd_pos_y) begin
                                add_cmd(AXIS_V, CMD_POSITION, py[31], cfg.position_accel,
                                        cfg.position_rpm, py[31] ? 32'd0 - py : py);
                                cmd_pos_y = py;
                            end
                        end
                    end
                    parse_ph = PH_HUNT;
                end
            endcase
        end
        if (new_count > 0) new_cmds[new_count-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------------
    task automatic add_row(logic req, logic [7:0] b, logic [31:0] now,
                           int nf = PREDICT, res_t c0 = '0, res_t c1 = '0);
        word_t w;
        w.req_type = req;
        w.rx_byte  = b;
        w.now_ms   = now;
        w.n_fixed  = nf;
        w.fix0     = c0;
        w.fix1     = c1;
        dir_tab.push_back(w);
    endtask

    // Queues one random-phase word. Time mostly creeps, and now and then
    // jumps far enough to pass the send interval or to let the link go stale.
    task automatic push_word(logic req, logic [7:0] b);
        word_t w;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 80)      gen_now = gen_now + $urandom_range(0, 2);
        else if (r < 96) gen_now = gen_now + $urandom_range(3, 60);
        else             gen_now = gen_now + $urandom_range(100, 450);
        w.req_type = req;
        w.rx_byte  = b;
        w.now_ms   = gen_now;
        w.n_fixed  = PREDICT;
        w.fix0     = '0;
        w.fix1     = '0;
        tx_words.push_back(w);
        gen_count++;
    endtask

    // A frame, with the odd poll slipped in between payload bytes; polls must
    // leave the parser where it was.
    task automatic push_frame(logic is_pos, logic [63:0] pl, logic [7:0] trailer);
        push_word(REQ_BYTE, BYTE_HEADER);
        push_word(REQ_BYTE, is_pos ? BYTE_POSITION : BYTE_SPEED);
        for (int i = 0; i < (is_pos ? 8 : 4); i++) begin
            if ($urandom_range(0, 15) == 0) push_word(REQ_POLL, 8'($urandom_range(0, 255)));
            push_word(REQ_BYTE, pl[8*i +: 8]);
        end
        push_word(REQ_BYTE, trailer);
    endtask

    // Speed values: fresh, a small step from the last, an extreme, or the same.
    function automatic logic [15:0] pick16(logic [15:0] prev);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(prev + $urandom_range(0, 8) - 16'd4);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return prev;
        endcase
    endfunction

    // Position targets: a repeat means no command for that axis.
    function automatic logic [31:0] pick32(logic [31:0] prev);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return prev + $urandom_range(0, 8) - 32'd4;
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return POS_SENTINEL;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return prev;
        endcase
    endfunction

    task automatic gen_random_phase(int n);
        int          kind;
        logic [7:0]  bad;
        gen_count = 0;
        while (gen_count < n) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                gen_sx = pick16(gen_sx);
                gen_sy = pick16(gen_sy);
                push_frame(1'b0, {32'd0, gen_sy, gen_sx}, BYTE_TRAILER);
            end else if (kind < 11) begin
                gen_px = pick32(gen_px);
                gen_py = pick32(gen_py);
                push_frame(1'b1, {gen_py, gen_px}, BYTE_TRAILER);
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 4)) push_word(REQ_POLL, 8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0: repeat ($urandom_range(1, 6))
                        push_word(REQ_BYTE, 8'($urandom_range(0, 255)));
                    1: begin
                        push_word(REQ_BYTE, BYTE_HEADER);
                        push_word(REQ_BYTE, BYTE_HEADER);
                    end
                    2: begin
                        bad = 8'($urandom_range(0, 255));
                        if (bad == BYTE_TRAILER) bad = BYTE_HEADER;
                        push_frame(1'($urandom_range(0, 1)), {$urandom, $urandom}, bad);
                    end
                    default: begin
                        // Cut short: the next frame's bytes land in this payload.
                        push_word(REQ_BYTE, BYTE_HEADER);
                        push_word(REQ_BYTE, $urandom_range(0, 1) ? BYTE_POSITION : BYTE_SPEED);
                        repeat ($urandom_range(0, 3))
                            push_word(REQ_BYTE, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
    endtask

    // Writes every register, one per cycle. Only called while nothing is in
    // flight, so the predictor may take the new setting at once.
    task automatic apply_cfg(input cfg_t c);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RX_TIMEOUT;
        cfg_wdata <= c.rx_timeout_ms;
        @(posedge aclk);
        cfg_index <= CFG_SEND_INTERVAL;
        cfg_wdata <= c.update_gap_ms;
        @(posedge aclk);
        cfg_index <= CFG_SPEED_DEADBAND;
        cfg_wdata <= c.speed_threshold;
        // The narrow registers get random upper bits, which must be dropped.
        @(posedge aclk);
        cfg_index <= CFG_SPEED_ACCEL;
        cfg_wdata <= {8'($urandom_range(0, 255)), c.speed_accel};
        @(posedge aclk);
        cfg_index <= CFG_POSITION_ACCEL;
        cfg_wdata <= {8'($urandom_range(0, 255)), c.position_accel};
        @(posedge aclk);
        cfg_index <= CFG_POSITION_RPM;
        cfg_wdata <= c.position_rpm;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg = c;
    endtask

    // Waits until every word has gone in and every command has come out, then
    // gives words that cause no command time to pass through the block.
    task automatic drain();
        do @(negedge aclk);
        while (tx_words.size() != 0 || s_valid || motor_cmd_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of words with gaps between them. The word taken at this
    // edge is predicted here, before the next one is put on the port.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_motor_cmds(cur_word);
            if (cur_word.n_fixed == PREDICT) begin
                for (int i = 0; i < new_count; i++) motor_cmd_q.push_back(new_cmds[i]);
            end else begin
                if (cur_word.n_fixed > 0) motor_cmd_q.push_back(cur_word.fix0);
                if (cur_word.n_fixed > 1) motor_cmd_q.push_back(cur_word.fix1);
            end
        end
        if (!aresetn || (s_valid && !s_ready)) begin
            // In reset, or a word is still on offer: leave the port alone.
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (tx_words.size() > 0) begin
            nxt_word = tx_words.pop_front();
            cur_word   <= nxt_word;
            s_valid    <= 1'b1;
            s_req_type <= nxt_word.req_type;
            s_rx_byte  <= nxt_word.rx_byte;
            s_now_ms   <= nxt_word.now_ms;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 30);
                // Roughly one burst in four runs straight on into the next.
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: changes its stall pattern now and then, and from time to time
    // holds off for a long stretch while the sender keeps offering, so that
    // the output queue fills and the input side has to stall.
    // ------------------------------------------------------------------------
    int        rx_cycle  = 0;
    int        next_hold = 600;
    int        hold_left = 0;
    int        mode_left = 0;
    rdy_mode_t rdy_mode  = RDY_ALWAYS;

    always @(posedge aclk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_cycle >= next_hold && s_valid) begin
            hold_left = HOLD_CYCLES;
            next_hold = rx_cycle + HOLD_SPACING;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rdy_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_HALF:   m_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                default:    m_ready <= ((rx_cycle % 8) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each command word taken is held against the oldest expectation.
    // ------------------------------------------------------------------------
    res_t want;

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (motor_cmd_q.size() == 0) begin
                $error("command word with no expectation waiting");
                errors++;
            end else begin
                want = motor_cmd_q.pop_front();
                check_field("axis", 32'(want.axis), 32'(m_axis));
                check_field("cmd_kind", 32'(want.cmd_kind), 32'(m_cmd_kind));
                check_field("direction", 32'(want.direction), 32'(m_direction));
                check_field("accel", 32'(want.accel), 32'(m_accel));
                check_field("speed_rpm", 32'(want.speed_rpm), 32'(m_speed_rpm));
                check_field("pulse_count", want.pulse_count, m_pulse_count);
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which work is pending but nothing moves.
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (tx_words.size() == 0 && !s_valid && motor_cmd_q.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Run sequence.
    // ------------------------------------------------------------------------
    initial begin
        cfg_t phase_cfg;
        reset_predictor();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, under the reset setting. Commands are typed in where
        // they follow plainly from the frame; other rows use the predictor.
        // Stale link with speed mode off: nothing happens.
        add_row(REQ_POLL, 8'h00, 32'hFFFF_FFFF, 0);
        // A header in the type position is dropped, so the speed byte after
        // it must not open a frame.
        add_row(REQ_BYTE, BYTE_HEADER, 32'd1);
        add_row(REQ_BYTE, BYTE_HEADER, 32'd2);
        add_row(REQ_BYTE, BYTE_SPEED, 32'd3);
        // Speed frame: horizontal -32768, vertical +32767.
        add_row(REQ_BYTE, BYTE_HEADER, 32'd10);
        add_row(REQ_BYTE, BYTE_SPEED, 32'd10);
        add_row(REQ_BYTE, 8'h00, 32'd10);
        add_row(REQ_BYTE, 8'h80, 32'd10);
        add_row(REQ_BYTE, 8'hFF, 32'd10);
        add_row(REQ_BYTE, 8'h7F, 32'd10);
        add_row(REQ_BYTE, BYTE_TRAILER, 32'd10, 0);
        add_row(REQ_POLL, 8'hFF, 32'd30, 2,
                res_t'{AXIS_H, CMD_SPEED, 1'b1, RST_SPEED_ACCEL, 16'h8000, 32'd0, 1'b0},
                res_t'{AXIS_V, CMD_SPEED, 1'b0, RST_SPEED_ACCEL, 16'h7FFF, 32'd0, 1'b1});
        // Interval passed but the speeds are unchanged: only the send time moves.
        add_row(REQ_POLL, 8'h00, 32'd55);
        // Link stale while in speed mode: both motors are stopped.
        add_row(REQ_POLL, 8'h00, 32'd300, 2,
                res_t'{AXIS_H, CMD_SPEED, 1'b0, 8'd0, 16'd0, 32'd0, 1'b0},
                res_t'{AXIS_V, CMD_SPEED, 1'b0, 8'd0, 16'd0, 32'd0, 1'b1});
        // Position frame: horizontal -2^31, vertical 2^31 - 1.
        add_row(REQ_BYTE, BYTE_HEADER, 32'd400);
        add_row(REQ_BYTE, BYTE_POSITION, 32'd400);
        add_row(REQ_BYTE, 8'h00, 32'd400);
        add_row(REQ_BYTE, 8'h00, 32'd400);
        add_row(REQ_BYTE, 8'h00, 32'd400);
        add_row(REQ_BYTE, 8'h80, 32'd400);
        add_row(REQ_BYTE, 8'hFF, 32'd400);
        add_row(REQ_BYTE, 8'hFF, 32'd400);
        add_row(REQ_BYTE, 8'hFF, 32'd400);
        add_row(REQ_BYTE, 8'h7F, 32'd400);
        add_row(REQ_BYTE, BYTE_TRAILER, 32'd400, 2,
                res_t'{AXIS_H, CMD_POSITION, 1'b1, RST_POSITION_ACCEL, RST_POSITION_RPM,
                       32'h8000_0000, 1'b0},
                res_t'{AXIS_V, CMD_POSITION, 1'b0, RST_POSITION_ACCEL, RST_POSITION_RPM,
                       32'h7FFF_FFFF, 1'b1});
        // Speed frame with a bad trailer: dropped, speed mode stays off.
        add_row(REQ_BYTE, BYTE_HEADER, 32'd420);
        add_row(REQ_BYTE, BYTE_SPEED, 32'd420);
        add_row(REQ_BYTE, 8'h12, 32'd420);
        add_row(REQ_BYTE, 8'h34, 32'd420);
        add_row(REQ_BYTE, 8'h56, 32'd420);
        add_row(REQ_BYTE, 8'h78, 32'd420);
        add_row(REQ_BYTE, 8'h00, 32'd420);
        add_row(REQ_POLL, 8'h00, 32'd450);
        foreach (dir_tab[i]) tx_words.push_back(dir_tab[i]);
        drain();

        // Random phases. The second and third use the extreme settings; the
        // fourth starts just short of the time counter wrapping round.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                1: phase_cfg = '{16'hFFFF, 16'h0000, 16'h0000, 8'hFF, 8'h00, 16'hFFFF};
                2: phase_cfg = '{16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 16'h0000};
                default: begin
                    phase_cfg.rx_timeout_ms   = 16'($urandom_range(10, 400));
                    phase_cfg.update_gap_ms   = 16'($urandom_range(0, 30));
                    phase_cfg.speed_threshold = 16'(($urandom_range(0, 3) == 0) ?
                                                    $urandom_range(0, 2000) :
                                                    $urandom_range(0, 8));
                    phase_cfg.speed_accel     = 8'($urandom_range(0, 255));
                    phase_cfg.position_accel  = 8'($urandom_range(0, 255));
                    phase_cfg.position_rpm    = 16'($urandom_range(0, 65535));
                end
            endcase
            apply_cfg(phase_cfg);
            gen_now = (p == 3) ? 32'hFFFF_FF00 : $urandom;
            gen_random_phase(PHASE_WORDS);
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/gcfc_pkg.sv
design/gcfc_parser.sv
design/gcfc_cmd.sv
design/gcfc_outq.sv
design/gimbal_command_frame_controller_unit.sv
design/gcfc_checker.sv
tb/gimbal_command_frame_controller_unit_tb.sv
